// ===== design/q2e_pkg.sv =====
// Package: shared types, constants and tables of the quaternion to Euler angle converter.
`default_nettype none

package q2e_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int MAX_STEPS        = 24;

  localparam int IN_W     = 16;
  localparam int OUT_W    = 16;
  localparam int CFG_W    = 16;
  localparam int TERM_FRAC = 24;
  localparam int QUO_W    = TERM_FRAC + 1;
  localparam int TERM_W   = TERM_FRAC + 2;
  localparam int CIN_W    = TERM_W + 1;
  localparam int CORD_W   = CIN_W + 3;
  localparam int ANG_W    = 24;
  localparam int THR_SHIFT = 10;

  localparam logic [CFG_W-1:0] THR_RESET = 16'd1;
  localparam logic signed [ANG_W-1:0] PI_Q20 = 24'sd3294199;
  localparam logic signed [31:0] INV_GAIN_Q30 = 32'sd652032874;
  localparam int ANGLE_LIMIT = 25736;

  typedef struct packed {
    logic signed [IN_W-1:0] quat_x;
    logic signed [IN_W-1:0] quat_y;
    logic signed [IN_W-1:0] quat_z;
    logic signed [IN_W-1:0] quat_w;
  } quat_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] roll_angle;
    logic signed [OUT_W-1:0] pitch_angle;
    logic signed [OUT_W-1:0] yaw_angle;
    logic                    gimbal_locked;
  } euler_t;

  // atan(2^-i) in Q.20, rounded to nearest
  function automatic logic signed [ANG_W-1:0] atan_q20(input int i);
    logic signed [ANG_W-1:0] v;
    case (i)
      0:  v = 24'sd823550;
      1:  v = 24'sd486170;
      2:  v = 24'sd256879;
      3:  v = 24'sd130396;
      4:  v = 24'sd65451;
      5:  v = 24'sd32757;
      6:  v = 24'sd16383;
      7:  v = 24'sd8192;
      8:  v = 24'sd4096;
      9:  v = 24'sd2048;
      10: v = 24'sd1024;
      11: v = 24'sd512;
      12: v = 24'sd256;
      13: v = 24'sd128;
      14: v = 24'sd64;
      15: v = 24'sd32;
      16: v = 24'sd16;
      17: v = 24'sd8;
      18: v = 24'sd4;
      19: v = 24'sd2;
      20: v = 24'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Q.20 angle to Q3.13: round half up, then clamp to plus or minus pi
  function automatic logic signed [OUT_W-1:0] to_q13(input logic signed [ANG_W-1:0] a);
    logic signed [ANG_W:0]   s;
    logic signed [ANG_W-7:0] r;
    logic signed [ANG_W-7:0] lim;
    lim = (ANG_W-6)'(ANGLE_LIMIT);
    s = (ANG_W+1)'(a) + (ANG_W+1)'(64);
    r = $signed(s[ANG_W:7]);
    if (r > lim) begin
      r = lim;
    end else if (r < -lim) begin
      r = -lim;
    end
    return OUT_W'(r);
  endfunction

endpackage

`default_nettype wire

// ===== design/q2e_if.sv =====
// Interfaces: quaternion input channel, Euler angle output channel, threshold write channel.
`default_nettype none

interface q2e_quat_if;
  logic          valid;
  logic          ready;
  q2e_pkg::quat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface q2e_euler_if;
  logic            valid;
  logic            ready;
  q2e_pkg::euler_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface q2e_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [q2e_pkg::CFG_W-1:0]   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== design/quaternion_to_euler_angles.sv =====
// Top level: quaternion to roll, pitch and yaw converter with gimbal-lock detection.
`default_nettype none

// Converts one quaternion (Q2.14) per cycle while not stalled into roll, pitch and yaw
// (Q3.13 radians). The pipeline takes a new item every clock unless stalled; its length is
// set by the 25-stage restoring divider that forms the seven rotation-matrix terms and the
// two CORDIC pipelines in series (yaw first, whose magnitude feeds the lock test and roll).
// A one-entry skid buffer at the input keeps quat_i.ready a register output; the whole
// pipeline stalls only while the output item waits. The threshold register resets to 1
// and may be written at any time the block is idle.

module quaternion_to_euler_angles #(
  parameter int CORDIC_STEPS = q2e_pkg::CORDIC_STEPS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  q2e_quat_if.sink       quat_i,
  q2e_euler_if.source    euler_o,
  q2e_cfg_if.sink        cfg_i
);

  localparam int NLANE  = 7;
  localparam int LN_T1  = 0;
  localparam int LN_T2  = 1;
  localparam int LN_ZXM = 2;
  localparam int LN_O1  = 3;
  localparam int LN_ZYP = 4;
  localparam int LN_ZXP = 5;
  localparam int LN_O2  = 6;

  localparam int NUM_W  = 36;
  localparam int NORM_W = 33;
  localparam int REM_W  = NORM_W + 1;
  localparam int TF     = q2e_pkg::TERM_FRAC;
  localparam int QW     = q2e_pkg::QUO_W;
  localparam int TW     = q2e_pkg::TERM_W;
  localparam int IW     = q2e_pkg::CIN_W;
  localparam int AW     = q2e_pkg::ANG_W;
  localparam int DVD_W  = NORM_W + TF + 1;
  localparam int DIV_ST = QW;
  localparam logic signed [TW-1:0] ONE_TERM = TW'(1) << TF;

  // ---------------------------------------------------------------- config
  logic [q2e_pkg::CFG_W-1:0] thr_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= q2e_pkg::THR_RESET;
    end else if (cfg_i.valid) begin
      thr_q <= cfg_i.data;
    end
  end

  // ---------------------------------------------------------------- flow control
  // Advance every stage together whenever the output register is free or taken.
  logic           en;
  logic           out_v_q;
  q2e_pkg::euler_t out_q;
  logic           skid_v_q;
  q2e_pkg::quat_t skid_q;
  q2e_pkg::quat_t src;
  logic           src_v;

  assign en           = !out_v_q || euler_o.ready;
  assign quat_i.ready = !skid_v_q;
  assign src          = skid_v_q ? skid_q : quat_i.data;
  assign src_v        = skid_v_q || quat_i.valid;

  // Park an item arriving during a stall; drain it on the next advance.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_v_q <= 1'b0;
    end else if (en) begin
      skid_v_q <= 1'b0;
    end else if (quat_i.valid && !skid_v_q) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!en && quat_i.valid && !skid_v_q) begin
      skid_q <= quat_i.data;
    end
  end

  // ---------------------------------------------------------------- stage 0: input
  logic           v0_q;
  q2e_pkg::quat_t p0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= src_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p0_q <= src;
    end
  end

  // ---------------------------------------------------------------- stage 1: products
  logic v1_q;
  logic signed [31:0] xx_q, yy_q, zz_q, ww_q, yx_q, zw_q, zx_q, yw_q, zy_q, xw_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      xx_q <= p0_q.quat_x * p0_q.quat_x;
      yy_q <= p0_q.quat_y * p0_q.quat_y;
      zz_q <= p0_q.quat_z * p0_q.quat_z;
      ww_q <= p0_q.quat_w * p0_q.quat_w;
      yx_q <= p0_q.quat_y * p0_q.quat_x;
      zw_q <= p0_q.quat_z * p0_q.quat_w;
      zx_q <= p0_q.quat_z * p0_q.quat_x;
      yw_q <= p0_q.quat_y * p0_q.quat_w;
      zy_q <= p0_q.quat_z * p0_q.quat_y;
      xw_q <= p0_q.quat_x * p0_q.quat_w;
    end
  end

  // ---------------------------------------------------------------- stage 2: numerators
  logic signed [NUM_W-1:0] exx, eyy, ezz, eww, eyx, ezw, ezx, eyw, ezy, exw, nrm;
  logic signed [NUM_W-1:0] num [NLANE];

  assign exx = NUM_W'(xx_q);
  assign eyy = NUM_W'(yy_q);
  assign ezz = NUM_W'(zz_q);
  assign eww = NUM_W'(ww_q);
  assign eyx = NUM_W'(yx_q);
  assign ezw = NUM_W'(zw_q);
  assign ezx = NUM_W'(zx_q);
  assign eyw = NUM_W'(yw_q);
  assign ezy = NUM_W'(zy_q);
  assign exw = NUM_W'(xw_q);
  assign nrm = exx + eyy + ezz + eww;

  assign num[LN_T1]  = nrm - (exx <<< 1) - (ezz <<< 1);
  assign num[LN_T2]  = (eyx - ezw) <<< 1;
  assign num[LN_ZXM] = (ezx - eyw) <<< 1;
  assign num[LN_O1]  = nrm - (exx <<< 1) - (eyy <<< 1);
  assign num[LN_ZYP] = (ezy + exw) <<< 1;
  assign num[LN_ZXP] = (ezx + eyw) <<< 1;
  assign num[LN_O2]  = nrm - (eyy <<< 1) - (ezz <<< 1);

  logic                    v2_q;
  logic [NLANE-1:0][NORM_W-1:0] mag2_q;
  logic [NLANE-1:0]        neg2_q;
  logic [NORM_W-1:0]       n2_q;
  logic                    nz2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  // Split each numerator into sign and magnitude for the unsigned divider.
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < NLANE; l++) begin
        neg2_q[l] <= num[l][NUM_W-1];
        mag2_q[l] <= num[l][NUM_W-1] ? NORM_W'(-num[l]) : NORM_W'(num[l]);
      end
      n2_q  <= NORM_W'(nrm);
      nz2_q <= (nrm != '0);
    end
  end

  // ---------------------------------------------------------------- divider
  // Restoring division of (|num| << 24) + n/2 by n, one quotient bit per stage.
  logic [NLANE-1:0][DVD_W-1:0] dv_q [DIV_ST+1];
  logic [NLANE-1:0][REM_W-1:0] rm_q [DIV_ST+1];
  logic [NLANE-1:0][QW-1:0]    qt_q [DIV_ST+1];
  logic [NLANE-1:0]            ng_q [DIV_ST+1];
  logic [NORM_W-1:0]           dn_q [DIV_ST+1];
  logic                        dz_q [DIV_ST+1];
  logic                        dvv_q [DIV_ST+1];

  logic [NLANE-1:0][DVD_W-1:0] dvd_init;

  always_comb begin
    for (int l = 0; l < NLANE; l++) begin
      dvd_init[l] = {1'b0, mag2_q[l], {TF{1'b0}}} + DVD_W'(n2_q >> 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dvv_q[0] <= 1'b0;
    end else if (en) begin
      dvv_q[0] <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < NLANE; l++) begin
        dv_q[0][l] <= dvd_init[l];
        rm_q[0][l] <= REM_W'(dvd_init[l][DVD_W-1:QW]);
        qt_q[0][l] <= '0;
      end
      ng_q[0] <= neg2_q;
      dn_q[0] <= n2_q;
      dz_q[0] <= nz2_q;
    end
  end

  for (genvar s = 0; s < DIV_ST; s++) begin : g_div
    localparam int BI = QW - 1 - s;
    logic [NLANE-1:0][REM_W-1:0] r;
    logic [NLANE-1:0]            ge;

    always_comb begin
      for (int l = 0; l < NLANE; l++) begin
        r[l]  = {rm_q[s][l][REM_W-2:0], dv_q[s][l][BI]};
        ge[l] = (r[l] >= {1'b0, dn_q[s]});
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dvv_q[s+1] <= 1'b0;
      end else if (en) begin
        dvv_q[s+1] <= dvv_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        for (int l = 0; l < NLANE; l++) begin
          rm_q[s+1][l] <= ge[l] ? (r[l] - {1'b0, dn_q[s]}) : r[l];
          qt_q[s+1][l] <= {qt_q[s][l][QW-2:0], ge[l]};
          dv_q[s+1][l] <= dv_q[s][l];
        end
        ng_q[s+1] <= ng_q[s];
        dn_q[s+1] <= dn_q[s];
        dz_q[s+1] <= dz_q[s];
      end
    end
  end

  // ---------------------------------------------------------------- term stage
  // Restore sign; a zero norm gives exactly 1.0 on the diagonal terms and 0 elsewhere.
  logic                  tv_q;
  logic signed [TW-1:0]  term_q [NLANE];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tv_q <= 1'b0;
    end else if (en) begin
      tv_q <= dvv_q[DIV_ST];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < NLANE; l++) begin
        if (dz_q[DIV_ST]) begin
          term_q[l] <= ng_q[DIV_ST][l] ? -TW'(qt_q[DIV_ST][l]) : TW'(qt_q[DIV_ST][l]);
        end else if (l == LN_T1 || l == LN_O1 || l == LN_O2) begin
          term_q[l] <= ONE_TERM;
        end else begin
          term_q[l] <= '0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- yaw CORDIC
  typedef struct packed {
    logic signed [TW-1:0] zyp;
    logic signed [TW-1:0] o1;
    logic signed [TW-1:0] zxm;
    logic signed [TW-1:0] o2;
    logic signed [TW-1:0] zxp;
  } yaw_side_t;

  yaw_side_t            ys_in, ys_out;
  logic                 yv;
  logic signed [AW-1:0] yaw_ang;
  logic signed [IW-1:0] yaw_mag;

  assign ys_in.zyp = term_q[LN_ZYP];
  assign ys_in.o1  = term_q[LN_O1];
  assign ys_in.zxm = term_q[LN_ZXM];
  assign ys_in.o2  = term_q[LN_O2];
  assign ys_in.zxp = term_q[LN_ZXP];

  q2e_cordic #(
    .STEPS  (CORDIC_STEPS),
    .SIDE_W ($bits(yaw_side_t))
  ) u_yaw (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (tv_q),
    .x_i     (IW'(term_q[LN_T1])),
    .y_i     (IW'(term_q[LN_T2])),
    .side_i  (ys_in),
    .valid_o (yv),
    .ang_o   (yaw_ang),
    .mag_o   (yaw_mag),
    .side_o  (ys_out)
  );

  // ---------------------------------------------------------------- lock stage
  // Lock when the horizontal magnitude falls below the threshold; swap pitch terms.
  logic                 lk;
  logic                 lv_q, lk_q;
  logic signed [IW-1:0] rx_q, ry_q, px_q, py_q;
  logic signed [AW-1:0] yawn_q;

  assign lk = $unsigned(yaw_mag) < {1'b0, thr_q, {q2e_pkg::THR_SHIFT{1'b0}}};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lv_q <= 1'b0;
    end else if (en) begin
      lv_q <= yv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      lk_q   <= lk;
      rx_q   <= yaw_mag;
      ry_q   <= -IW'(ys_out.zyp);
      yawn_q <= lk ? '0 : -yaw_ang;
      if (lk) begin
        px_q <= IW'(ys_out.o2);
        py_q <= -IW'(ys_out.zxp);
      end else begin
        px_q <= IW'(ys_out.o1);
        py_q <= IW'(ys_out.zxm);
      end
    end
  end

  // ---------------------------------------------------------------- roll and pitch
  logic                 rv, pv;
  logic signed [AW-1:0] roll_ang, pitch_ang;
  logic signed [IW-1:0] roll_mag, pitch_mag;
  logic signed [AW-1:0] yaw_late;
  logic                 lk_late;

  q2e_cordic #(
    .STEPS  (CORDIC_STEPS),
    .SIDE_W (AW)
  ) u_roll (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (lv_q),
    .x_i     (rx_q),
    .y_i     (ry_q),
    .side_i  (yawn_q),
    .valid_o (rv),
    .ang_o   (roll_ang),
    .mag_o   (roll_mag),
    .side_o  (yaw_late)
  );

  q2e_cordic #(
    .STEPS  (CORDIC_STEPS),
    .SIDE_W (1)
  ) u_pitch (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (lv_q),
    .x_i     (px_q),
    .y_i     (py_q),
    .side_i  (lk_q),
    .valid_o (pv),
    .ang_o   (pitch_ang),
    .mag_o   (pitch_mag),
    .side_o  (lk_late)
  );

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= rv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.roll_angle    <= q2e_pkg::to_q13(-roll_ang);
      out_q.pitch_angle   <= q2e_pkg::to_q13(-pitch_ang);
      out_q.yaw_angle     <= q2e_pkg::to_q13(yaw_late);
      out_q.gimbal_locked <= lk_late;
    end
  end

  assign euler_o.valid = out_v_q;
  assign euler_o.data  = out_q;

  // ---------------------------------------------------------------- checks
  // The two parallel CORDIC lanes must stay in step.
  a_lanes_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rv == pv) && (!rv || (roll_mag >= 0 && pitch_mag >= 0)))
    else $error("roll and pitch pipelines out of step");

  // Yaw is forced to zero under gimbal lock.
  a_lock_yaw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_q.gimbal_locked |-> out_q.yaw_angle == '0)
    else $error("nonzero yaw under gimbal lock");

  // The skid buffer fills only on a stalled cycle.
  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(!en))
    else $error("skid buffer filled while pipeline advanced");

  // Roll stays within the clamp range.
  a_roll_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> (out_q.roll_angle <= 16'sd25736) && (out_q.roll_angle >= -16'sd25736))
    else $error("roll outside clamp range");

endmodule

`default_nettype wire

// ===== design/q2e_cordic.sv =====
// Pipelined vectoring CORDIC: angle of (x, y) in Q.20 and gain-corrected magnitude.
`default_nettype none

module q2e_cordic #(
  parameter int STEPS  = q2e_pkg::CORDIC_STEPS_DEF,
  parameter int SIDE_W = 1
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic signed [q2e_pkg::CIN_W-1:0]  x_i,
  input  logic signed [q2e_pkg::CIN_W-1:0]  y_i,
  input  logic [SIDE_W-1:0]                 side_i,
  output logic                              valid_o,
  output logic signed [q2e_pkg::ANG_W-1:0]  ang_o,
  output logic signed [q2e_pkg::CIN_W-1:0]  mag_o,
  output logic [SIDE_W-1:0]                 side_o
);

  localparam int NIT = (STEPS < q2e_pkg::MAX_STEPS) ? STEPS : q2e_pkg::MAX_STEPS;
  localparam int CW  = q2e_pkg::CORD_W;
  localparam int IW  = q2e_pkg::CIN_W;
  localparam int AW  = q2e_pkg::ANG_W;
  localparam int PW  = CW + 32;
  localparam logic signed [PW-1:0] HALF = PW'(1) << 29;

  logic signed [CW-1:0] xs_q [NIT+1];
  logic signed [CW-1:0] ys_q [NIT+1];
  logic signed [AW-1:0] zs_q [NIT+1];
  logic                 zr_q [NIT+1];
  logic [SIDE_W-1:0]    sd_q [NIT+1];
  logic                 vs_q [NIT+1];

  logic signed [CW-1:0] x0_d, y0_d;
  logic signed [AW-1:0] z0_d;

  // pre-rotate by pi when x is negative
  always_comb begin
    if (x_i[IW-1]) begin
      x0_d = -CW'(x_i);
      y0_d = -CW'(y_i);
      z0_d = y_i[IW-1] ? -q2e_pkg::PI_Q20 : q2e_pkg::PI_Q20;
    end else begin
      x0_d = CW'(x_i);
      y0_d = CW'(y_i);
      z0_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vs_q[0] <= 1'b0;
    end else if (en_i) begin
      vs_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xs_q[0] <= x0_d;
      ys_q[0] <= y0_d;
      zs_q[0] <= z0_d;
      zr_q[0] <= (x_i == '0) && (y_i == '0);
      sd_q[0] <= side_i;
    end
  end

  for (genvar i = 0; i < NIT; i++) begin : g_iter
    localparam logic signed [AW-1:0] AT = q2e_pkg::atan_q20(i);
    logic signed [CW-1:0] dx, dy;
    assign dx = ys_q[i] >>> i;
    assign dy = xs_q[i] >>> i;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vs_q[i+1] <= 1'b0;
      end else if (en_i) begin
        vs_q[i+1] <= vs_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!ys_q[i][CW-1]) begin
          xs_q[i+1] <= xs_q[i] + dx;
          ys_q[i+1] <= ys_q[i] - dy;
          zs_q[i+1] <= zs_q[i] + AT;
        end else begin
          xs_q[i+1] <= xs_q[i] - dx;
          ys_q[i+1] <= ys_q[i] + dy;
          zs_q[i+1] <= zs_q[i] - AT;
        end
        zr_q[i+1] <= zr_q[i];
        sd_q[i+1] <= sd_q[i];
      end
    end
  end

  logic signed [PW-1:0] prod_q;
  logic signed [PW-1:0] rnd;
  logic signed [AW-1:0] ang_q;
  logic [SIDE_W-1:0]    side_q;
  logic                 vo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en_i) begin
      vo_q <= vs_q[NIT];
    end
  end

  // gain correction multiply; a zero vector gives angle zero
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= PW'(xs_q[NIT]) * PW'(q2e_pkg::INV_GAIN_Q30);
      ang_q  <= zr_q[NIT] ? '0 : zs_q[NIT];
      side_q <= sd_q[NIT];
    end
  end

  assign rnd     = prod_q + HALF;
  assign mag_o   = $signed(rnd[30 +: IW]);
  assign ang_o   = ang_q;
  assign side_o  = side_q;
  assign valid_o = vo_q;

endmodule

`default_nettype wire

// ===== bench/q2e_tb_if.sv =====
// Bench-side note: channel interfaces come from the design; this file holds the bench utilities.
`timescale 1ns / 100ps

package q2e_tb_util_pkg;
  localparam int WATCHDOG_CYCLES = 20000;
endpackage

// ===== bench/q2e_checker.sv =====
// Checker: predicts Euler angles from accepted quaternions and compares each result item.
`timescale 1ns / 100ps

module q2e_checker #(
  parameter int CORDIC_STEPS = q2e_pkg::CORDIC_STEPS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic quat_valid_i,
  input  logic quat_ready_i,
  input  q2e_pkg::quat_t quat_data_i,
  input  logic euler_valid_i,
  input  logic euler_ready_i,
  input  q2e_pkg::euler_t euler_data_i,
  input  logic cfg_valid_i,
  input  logic cfg_ready_i,
  input  logic [q2e_pkg::CFG_W-1:0] cfg_data_i,
  output int   fail_count_o,
  output int   pending_o,
  output int   locked_seen_o
);

  q2e_pkg::euler_t angles_q[$];
  logic [q2e_pkg::CFG_W-1:0] lock_thr;

  function automatic longint fl_asr(longint v, int s);
    if (v >= 0) return v >>> s;
    return -(((-v) - 1) >>> s) - 1;
  endfunction

  function automatic longint term_ratio(longint num, longint n);
    longint unsigned mag, q;
    mag = (num < 0 ? -num : num);
    mag = mag << q2e_pkg::TERM_FRAC;
    q = (mag + longint'(n) / 2) / longint'(n);
    return num < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic int atan_tab(int i);
    int t[21] = '{823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192, 4096, 2048,
                  1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1};
    return (i < 21) ? t[i] : 0;
  endfunction

  function automatic longint vec_angle(longint x, longint y, output longint mag);
    longint z, dx, dy;
    z = 0;
    if (x == 0 && y == 0) begin
      mag = 0;
      return 0;
    end
    if (x < 0) begin
      z = (y >= 0) ? 3294199 : -3294199;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < CORDIC_STEPS && i < q2e_pkg::MAX_STEPS; i++) begin
      dx = fl_asr(y, i);
      dy = fl_asr(x, i);
      if (y >= 0) begin
        x += dx; y -= dy; z += longint'(atan_tab(i));
      end else begin
        x -= dx; y += dy; z -= longint'(atan_tab(i));
      end
    end
    mag = fl_asr(x * 64'sd652032874 + (64'sd1 << 29), 30);
    return z;
  endfunction

  function automatic logic signed [q2e_pkg::OUT_W-1:0] angle_q13(longint a);
    longint r;
    r = fl_asr(a + 64, 7);
    if (r > q2e_pkg::ANGLE_LIMIT) r = q2e_pkg::ANGLE_LIMIT;
    if (r < -q2e_pkg::ANGLE_LIMIT) r = -q2e_pkg::ANGLE_LIMIT;
    return q2e_pkg::OUT_W'(r);
  endfunction

  function automatic q2e_pkg::euler_t predict_angles(q2e_pkg::quat_t q,
                                                     logic [q2e_pkg::CFG_W-1:0] thr);
    longint x, y, z, w, xx, yy, zz, n;
    longint t1, t2, a_zxm, a_oxy, a_zyp, a_zxp, a_oyz, yaw, pitch, roll, h, dm;
    q2e_pkg::euler_t e;
    x = q.quat_x; y = q.quat_y; z = q.quat_z; w = q.quat_w;
    xx = x * x; yy = y * y; zz = z * z;
    n = xx + yy + zz + w * w;
    if (n > 0) begin
      t1 = term_ratio(n - 2 * xx - 2 * zz, n);
      t2 = term_ratio(2 * (y * x - z * w), n);
      a_zxm = term_ratio(2 * (z * x - y * w), n);
      a_oxy = term_ratio(n - 2 * xx - 2 * yy, n);
      a_zyp = term_ratio(2 * (z * y + x * w), n);
      a_zxp = term_ratio(2 * (z * x + y * w), n);
      a_oyz = term_ratio(n - 2 * yy - 2 * zz, n);
    end else begin
      t1 = 64'sd1 << 24; a_oxy = t1; a_oyz = t1;
      t2 = 0; a_zxm = 0; a_zyp = 0; a_zxp = 0;
    end
    yaw = -vec_angle(t1, t2, h);
    e.gimbal_locked = (h < (longint'(thr) << q2e_pkg::THR_SHIFT));
    roll = -vec_angle(h, -a_zyp, dm);
    if (!e.gimbal_locked) begin
      pitch = -vec_angle(a_oxy, a_zxm, dm);
    end else begin
      pitch = -vec_angle(a_oyz, -a_zxp, dm);
      yaw = 0;
    end
    e.roll_angle = angle_q13(roll);
    e.pitch_angle = angle_q13(pitch);
    e.yaw_angle = angle_q13(yaw);
    return e;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    q2e_pkg::euler_t exp_e;
    if (!rst_ni) begin
      lock_thr <= q2e_pkg::THR_RESET;
      fail_count_o <= 0;
      locked_seen_o <= 0;
      angles_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) lock_thr <= cfg_data_i;
      if (quat_valid_i && quat_ready_i) angles_q.push_back(predict_angles(quat_data_i, lock_thr));
      if (euler_valid_i && euler_ready_i) begin
        if (angles_q.size() == 0) begin
          $error("result item with no expectation");
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_e = angles_q.pop_front();
          if (euler_data_i.gimbal_locked) locked_seen_o <= locked_seen_o + 1;
          if (exp_e !== euler_data_i) begin
            fail_count_o <= fail_count_o + 1;
            if (exp_e.roll_angle !== euler_data_i.roll_angle)
              $error("roll_angle exp %0d got %0d", exp_e.roll_angle, euler_data_i.roll_angle);
            if (exp_e.pitch_angle !== euler_data_i.pitch_angle)
              $error("pitch_angle exp %0d got %0d", exp_e.pitch_angle, euler_data_i.pitch_angle);
            if (exp_e.yaw_angle !== euler_data_i.yaw_angle)
              $error("yaw_angle exp %0d got %0d", exp_e.yaw_angle, euler_data_i.yaw_angle);
            if (exp_e.gimbal_locked !== euler_data_i.gimbal_locked)
              $error("gimbal_locked exp %0b got %0b", exp_e.gimbal_locked,
                     euler_data_i.gimbal_locked);
          end
        end
      end
    end
  end

  assign pending_o = angles_q.size();

endmodule

// ===== bench/quaternion_to_euler_angles_tb.sv =====
// Testbench top: drives quaternions and threshold writes, stalls the output, gives the verdict.
`timescale 1ns / 100ps

module quaternion_to_euler_angles_tb;

  localparam int PIPE_LAT = 35 + 2 * q2e_pkg::CORDIC_STEPS_DEF;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count, pending, locked_seen;
  int   idle_cycles;
  int   accepted;
  bit   quiet_phase;

  q2e_quat_if  quat_ch();
  q2e_euler_if euler_ch();
  q2e_cfg_if   cfg_ch();

  // Free-running 12 ns clock.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  quaternion_to_euler_angles i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .quat_i (quat_ch.sink),
    .euler_o(euler_ch.source),
    .cfg_i  (cfg_ch.sink)
  );

  q2e_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .quat_valid_i  (quat_ch.valid),
    .quat_ready_i  (quat_ch.ready),
    .quat_data_i   (quat_ch.data),
    .euler_valid_i (euler_ch.valid),
    .euler_ready_i (euler_ch.ready),
    .euler_data_i  (euler_ch.data),
    .cfg_valid_i   (cfg_ch.valid),
    .cfg_ready_i   (cfg_ch.ready),
    .cfg_data_i    (cfg_ch.data),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .locked_seen_o (locked_seen)
  );

  initial begin
    quat_ch.valid = 1'b0;
    quat_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    euler_ch.ready = 1'b0;
  end

  // Output side: hold ready low in random bursts, none in the quiet phase.
  initial begin : result_sink
    int gap;
    @(posedge clk_i);
    forever begin
      euler_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
      if (!quiet_phase && $urandom_range(0, 2) == 0) begin
        gap = $urandom_range(1, 7);
        euler_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  end

  // Watchdog: end the run when nothing is accepted for too long.
  always @(posedge clk_i) begin
    if ((quat_ch.valid && quat_ch.ready) || (euler_ch.valid && euler_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || !rst_ni)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > q2e_tb_util_pkg::WATCHDOG_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Send one item and wait for its acceptance; optionally idle first.
  task automatic send_quat(input q2e_pkg::quat_t q);
    if (!quiet_phase && $urandom_range(0, 4) == 0) begin
      quat_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    quat_ch.valid <= 1'b1;
    quat_ch.data <= q;
    @(posedge clk_i);
    while (!quat_ch.ready) @(posedge clk_i);
    accepted++;
  endtask

  task automatic drain_results();
    quat_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (PIPE_LAT + 4) @(posedge clk_i);
  endtask

  // Write the threshold only while the pipeline is empty.
  task automatic write_threshold(input logic [q2e_pkg::CFG_W-1:0] thr);
    drain_results();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= thr;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic signed [15:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'sd0;
      3: return 16'($signed($urandom_range(0, 64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  // About one quaternion in four near a gimbal-lock pose, so the lock path sees real traffic.
  function automatic q2e_pkg::quat_t rand_quat();
    q2e_pkg::quat_t q;
    int a;
    if ($urandom_range(0, 3) == 0) begin
      a = $urandom_range(0, 11585);
      q.quat_x = 16'($signed(a));
      q.quat_z = 16'($signed(a) + $signed($urandom_range(0, 8)) - 4);
      q.quat_y = $urandom_range(0, 1) ? 16'sd11585 : -16'sd11585;
      q.quat_w = 16'($signed($urandom_range(0, 8)) - 4);
      if ($urandom_range(0, 1)) q.quat_x = -q.quat_x;
    end else begin
      q.quat_x = rand_comp();
      q.quat_y = rand_comp();
      q.quat_z = rand_comp();
      q.quat_w = rand_comp();
    end
    return q;
  endfunction

  initial begin : stimulus
    q2e_pkg::quat_t dq[$];
    q2e_pkg::quat_t q;
    logic [q2e_pkg::CFG_W-1:0] thr_list[5] = '{16'd0, 16'd1, 16'd400, 16'd4096, 16'hFFFF};
    accepted = 0;
    quiet_phase = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: zero norm, identity, axis extremes, lock poses, sign extremes.
    dq.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sd0});
    dq.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sd16384});
    dq.push_back('{16'sd16384, 16'sd0, 16'sd0, 16'sd0});
    dq.push_back('{16'sd0, 16'sd16384, 16'sd0, 16'sd0});
    dq.push_back('{16'sd0, 16'sd0, 16'sd16384, 16'sd0});
    dq.push_back('{16'sd0, -16'sd16384, 16'sd0, 16'sd0});
    dq.push_back('{16'sd0, 16'sd11585, 16'sd0, 16'sd11585});
    dq.push_back('{16'sd0, -16'sd11585, 16'sd0, 16'sd11585});
    dq.push_back('{16'sd11585, 16'sd11585, 16'sd11585, 16'sd11585});
    dq.push_back('{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF});
    dq.push_back('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000});
    dq.push_back('{16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF});
    dq.push_back('{16'sd1, 16'sd0, 16'sd0, 16'sd0});
    dq.push_back('{-16'sd1, -16'sd1, 16'sd0, 16'sd0});
    dq.push_back('{16'sd0, 16'sd0, 16'sd0, -16'sd16384});
    dq.push_back('{16'sd5000, 16'sd5000, -16'sd5000, -16'sd5000});
    foreach (dq[i]) send_quat(dq[i]);

    // Hold off until every expected result is in, set the threshold to 0, then resume.
    write_threshold(16'd0);
    foreach (dq[i]) send_quat(dq[i]);

    // Random phases over several thresholds, extremes included.
    for (int p = 0; p < 5; p++) begin
      write_threshold(thr_list[p]);
      for (int k = 0; k < 330; k++) send_quat(rand_quat());
    end
    write_threshold(16'($urandom_range(2, 2000)));
    quiet_phase = 1;
    for (int k = 0; k < 250; k++) send_quat(rand_quat());

    drain_results();
    $display("Sent %0d quaternions over six threshold settings; %0d results flagged lock.",
             accepted, locked_seen);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
